@@ design/alfl_pkg.sv @@
// shared types, codes and defaults for the array linked list with free list
// used by alfl_cell and array_linked_list_free_list; no dependencies
package alfl_pkg;

  // default store size
  localparam int NODE_COUNT_DEF = 16;

  typedef logic signed [31:0] word_t;

  // request and response payloads
  typedef struct packed {
    logic [1:0] command;
    word_t      value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    word_t      item_value;
    logic       last;
  } rsp_t;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LIST   = 2'd2;

  // status codes
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_ELEMENT   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // cell moves
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_RIGHT = 2'd1;
  localparam logic [1:0] OP_LEFT  = 2'd2;

  // per-cell control
  typedef struct packed {
    logic [1:0] op;
    logic       load;
  } cell_ctl_t;

endpackage

@@ design/alfl_cell.sv @@
// one list position of the cell chain: holds a stored value and moves it
// toward the head or the tail; depends on alfl_pkg
module alfl_cell (
  input  logic                 clk,
  input  alfl_pkg::cell_ctl_t  ctl,
  input  alfl_pkg::word_t      left_value,
  input  alfl_pkg::word_t      right_value,
  input  alfl_pkg::word_t      inject_value,
  output alfl_pkg::word_t      value
);
  import alfl_pkg::*;

  // take from a neighbor, or the value wrapped around from the head
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_RIGHT: value <= left_value;
      OP_LEFT:  value <= ctl.load ? inject_value : right_value;
      OP_HOLD:  value <= value;
      default:  value <= value;
    endcase
  end

endmodule

@@ design/array_linked_list_free_list.sv @@
// array linked list with free list, held as an ordered chain of cells (head at cell 0).
// insert, empty list and unused codes answer in the cycle after the request; remove walks
// every node through the head before it answers; list gives one element per taken response.
// a new request is taken only once the previous one is done and the response slot is free.
// reset clears the control state and leaves the list empty; stored values need no clear.
module array_linked_list_free_list #(
  parameter int NODE_COUNT = alfl_pkg::NODE_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  alfl_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output alfl_pkg::rsp_t rsp_data
);
  import alfl_pkg::*;

  localparam int CW = $clog2(NODE_COUNT + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;

  logic [1:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] remaining, remaining_next;
  logic          found, found_next;
  word_t         key, key_next;

  logic          slot_free, accept, emit, tail_load;
  logic [1:0]    cell_op;
  logic [CW-1:0] tail;
  rsp_t          emit_data;

  word_t         cell_value [NODE_COUNT];
  cell_ctl_t     cell_ctl   [NODE_COUNT];

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && slot_free;
  assign accept    = req_valid && req_ready;
  assign tail      = count - CW'(1);

  // cell chain: left neighbor toward the head, right toward the tail
  for (genvar i = 0; i < NODE_COUNT; i++) begin : g_cell
    word_t left_in, right_in;

    if (i == 0) begin : g_head
      assign left_in = req_data.value;
    end else begin : g_body
      assign left_in = cell_value[i-1];
    end

    if (i == NODE_COUNT - 1) begin : g_end
      assign right_in = cell_value[0];
    end else begin : g_mid
      assign right_in = cell_value[i+1];
    end

    assign cell_ctl[i].op   = cell_op;
    assign cell_ctl[i].load = tail_load && (CW'(i) == tail);

    alfl_cell u_cell (
      .clk          (clk),
      .ctl          (cell_ctl[i]),
      .left_value   (left_in),
      .right_value  (right_in),
      .inject_value (cell_value[0]),
      .value        (cell_value[i])
    );
  end

  // sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    found_next     = found;
    key_next       = key;
    cell_op        = OP_HOLD;
    tail_load      = 1'b0;
    emit           = 1'b0;
    emit_data      = '{status: ST_DONE, item_value: '0, last: 1'b1};

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_data.command)
            CMD_INSERT: begin
              emit = 1'b1;
              if (count == CW'(NODE_COUNT)) begin
                emit_data.status = ST_FULL;
              end else begin
                cell_op    = OP_RIGHT;
                count_next = count + CW'(1);
              end
            end
            CMD_REMOVE: begin
              key_next       = req_data.value;
              found_next     = 1'b0;
              remaining_next = count;
              state_next     = S_WALK;
            end
            CMD_LIST: begin
              if (count == '0) begin
                emit             = 1'b1;
                emit_data.status = ST_EMPTY;
              end else begin
                remaining_next = count;
                state_next     = S_LIST;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      // rotate every node once; the first match is dropped instead of wrapped
      S_WALK: begin
        if (remaining == '0) begin
          if (slot_free) begin
            emit             = 1'b1;
            emit_data.status = found ? ST_DONE : ST_NOT_FOUND;
            state_next       = S_IDLE;
          end
        end else begin
          cell_op        = OP_LEFT;
          remaining_next = remaining - CW'(1);
          if (!found && (cell_value[0] == key)) begin
            found_next = 1'b1;
            count_next = count - CW'(1);
          end else begin
            tail_load = 1'b1;
          end
        end
      end

      // emit the head and wrap it to the tail, one node per taken result
      S_LIST: begin
        if (slot_free) begin
          emit                 = 1'b1;
          emit_data.status     = ST_ELEMENT;
          emit_data.item_value = cell_value[0];
          emit_data.last       = (remaining == CW'(1));
          cell_op              = OP_LEFT;
          tail_load            = 1'b1;
          remaining_next       = remaining - CW'(1);
          if (remaining == CW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      found     <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      found     <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp_data <= emit_data;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(NODE_COUNT))
    else $error("node count above store size");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req_data.command == CMD_INSERT && count != CW'(NODE_COUNT))
      |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the list");

  a_walk_no_growth: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> (count <= $past(count)))
    else $error("remove walk grew the list");

  a_list_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST && slot_free && remaining == CW'(1))
      |=> (state == S_IDLE && rsp_valid && rsp_data.last))
    else $error("list did not end on the tail");

endmodule
